// File: rtl/core/tabular_q_learning_engine_top_defines.svh
// Assertion macros for the tabular Q-learning engine.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef TABULAR_Q_LEARNING_ENGINE_TOP_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TQLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tqle_pkg.sv
// Shared types and constants for the tabular Q-learning engine.
// Used by the top level; has no dependencies of its own.
`default_nettype none

package tqle_pkg;

  // Row geometry: four actions per state.
  localparam int unsigned NUM_ACTIONS = 4;
  localparam int unsigned ACT_W       = 2;

  // Configuration port address width (eight 32-bit registers).
  localparam int unsigned CFG_ADDR_W = 5;

  // Epsilon decay numerator (x/256) and percent scale of the explore test.
  localparam logic [15:0] DECAY_NUM     = 16'd251;
  localparam logic [14:0] EXPLORE_SCALE = 15'd100;

  // Register reset values.
  localparam logic [7:0] LEARN_RATE_RST      = 8'd26;
  localparam logic [7:0] DISCOUNT_RST        = 8'd128;
  localparam logic [7:0] EXPLORE_START_RST   = 8'd230;
  localparam logic [7:0] EXPLORE_FLOOR_RST   = 8'd128;
  localparam logic [7:0] REWARD_FORWARD_RST  = 8'hF6;
  localparam logic [7:0] REWARD_BACKWARD_RST = 8'hFE;
  localparam logic [7:0] REWARD_STOP_RST     = 8'hFF;
  localparam logic [7:0] REWARD_LEFT_RST     = 8'h0A;
  localparam logic [7:0] EPSILON_RST         = 8'd230;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_LEARN_RATE      = 3'd0,
    REG_DISCOUNT        = 3'd1,
    REG_EXPLORE_START   = 3'd2,
    REG_EXPLORE_FLOOR   = 3'd3,
    REG_REWARD_FORWARD  = 3'd4,
    REG_REWARD_BACKWARD = 3'd5,
    REG_REWARD_STOP     = 3'd6,
    REG_REWARD_LEFT     = 3'd7
  } reg_idx_e;

  // Command opcodes.
  typedef enum logic {
    OP_LEARN = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One command transfer.
  typedef struct packed {
    op_e        opcode;
    logic [6:0] draw;
    logic [1:0] random_action;
    logic [3:0] query_state;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] q_value;
    logic [3:0]         state_index;
    logic               explored;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/tqle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tqle_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 40,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/tabular_q_learning_engine_top.sv
// A greedy learn scans the current row and then the next one, an exploring learn only the next
// row and a query its own; a query of an out-of-range state answers without raising busy.
// Otherwise busy clears as the result shows, and no new item is taken while busy is high; a row
// scan (one table read per action) and a shared multiplier used three times under a small
// sequencer set the pace. Reset: a clearing pass writes every table entry to zero with busy high.
// Results are shown for one cycle with done_o; the receiver cannot stall them.
`default_nettype none
`include "tabular_q_learning_engine_top_defines.svh"

module tabular_q_learning_engine_top #(
  parameter int unsigned NUM_STATES = 10,
  parameter int unsigned Q_WIDTH    = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire tqle_pkg::cmd_t                     cmd_i,
  // Result channel
  output logic                                    done_o,
  output tqle_pkg::result_t                       result_o,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tqle_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);

  import tqle_pkg::*;

  localparam int unsigned DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int unsigned SW     = $clog2(NUM_STATES);
  localparam int unsigned ADDR_W = SW + ACT_W;
  localparam int unsigned TW     = ((Q_WIDTH > 16) ? Q_WIDTH : 16) + 1;
  localparam int unsigned PW     = TW + 10;
  localparam int unsigned AW     = PW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_CUR,
    ST_SCAN_NEXT,
    ST_SCAN_QRY,
    ST_READ_OLD,
    ST_MUL_G,
    ST_MUL_OLD,
    ST_MUL_TGT,
    ST_ACC,
    ST_WRITE
  } state_e;

  // Configuration registers
  logic [7:0] learn_rate_q, discount_q, explore_start_q, explore_floor_q;
  logic [7:0] reward_fwd_q, reward_bwd_q, reward_stop_q, reward_left_q;
  logic       cfg_wr;

  // Sequencer and datapath registers
  state_e                    state_q, state_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [ADDR_W-1:0]         clr_q, clr_d;
  logic [SW-1:0]             st_q, st_d;
  logic [SW-1:0]             cur_state_q, cur_state_d;
  logic [7:0]                eps_q, eps_d;
  logic [ACT_W-1:0]          act_q, act_d;
  logic                      expl_q, expl_d;
  logic signed [Q_WIDTH-1:0] best_val_q, best_val_d;
  logic [ACT_W-1:0]          best_idx_q, best_idx_d;
  logic signed [Q_WIDTH-1:0] old_q, old_d;
  logic signed [TW-1:0]      target_q, target_d;
  logic signed [PW-1:0]      prod_q, prod_d;
  logic signed [AW-1:0]      acc_q, acc_d;
  logic                      done_q, done_d;
  result_t                   result_q, result_d;

  // Table memory signals
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [Q_WIDTH-1:0]        mem_wdata;
  logic [ADDR_W-1:0]         mem_raddr;
  logic signed [Q_WIDTH-1:0] mem_rdata;

  // Combinational helpers
  logic [SW-1:0]             next_st;
  logic [ACT_W-1:0]          scan_ent;
  logic                      scan_take;
  logic [ACT_W-1:0]          scan_idx;
  logic signed [Q_WIDTH-1:0] scan_val;
  logic signed [7:0]         reward;
  logic signed [TW-1:0]      mul_a;
  logic signed [9:0]         mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [AW-1:0]      acc_sh;
  logic                      nv_fits;
  logic signed [Q_WIDTH-1:0] nv_sat;
  logic [7:0]                eps_dec;
  logic                      explore;
  logic                      qs_in_range;

  // Configuration register file; writes complete on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q    <= LEARN_RATE_RST;
      discount_q      <= DISCOUNT_RST;
      explore_start_q <= EXPLORE_START_RST;
      explore_floor_q <= EXPLORE_FLOOR_RST;
      reward_fwd_q    <= REWARD_FORWARD_RST;
      reward_bwd_q    <= REWARD_BACKWARD_RST;
      reward_stop_q   <= REWARD_STOP_RST;
      reward_left_q   <= REWARD_LEFT_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_LEARN_RATE:      learn_rate_q    <= pwdata[7:0];
        REG_DISCOUNT:        discount_q      <= pwdata[7:0];
        REG_EXPLORE_START:   explore_start_q <= pwdata[7:0];
        REG_EXPLORE_FLOOR:   explore_floor_q <= pwdata[7:0];
        REG_REWARD_FORWARD:  reward_fwd_q    <= pwdata[7:0];
        REG_REWARD_BACKWARD: reward_bwd_q    <= pwdata[7:0];
        REG_REWARD_STOP:     reward_stop_q   <= pwdata[7:0];
        REG_REWARD_LEFT:     reward_left_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_LEARN_RATE:      prdata = {24'd0, learn_rate_q};
      REG_DISCOUNT:        prdata = {24'd0, discount_q};
      REG_EXPLORE_START:   prdata = {24'd0, explore_start_q};
      REG_EXPLORE_FLOOR:   prdata = {24'd0, explore_floor_q};
      REG_REWARD_FORWARD:  prdata = {24'd0, reward_fwd_q};
      REG_REWARD_BACKWARD: prdata = {24'd0, reward_bwd_q};
      REG_REWARD_STOP:     prdata = {24'd0, reward_stop_q};
      REG_REWARD_LEFT:     prdata = {24'd0, reward_left_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Q table storage.
  tqle_ram #(
    .WIDTH (Q_WIDTH),
    .DEPTH (DEPTH)
  ) u_qtable (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Successor state, wrapping at the state count.
  assign next_st = (st_q == SW'(NUM_STATES - 1)) ? '0 : st_q + SW'(1);

  // Running argmax: the entry read in the previous cycle against the best so far.
  // A strictly greater value wins, so the lowest action keeps a tie.
  assign scan_ent  = ACT_W'(cnt_q - 3'd1);
  assign scan_take = (cnt_q == 3'd1) || (mem_rdata > best_val_q);
  assign scan_idx  = scan_take ? scan_ent : best_idx_q;
  assign scan_val  = scan_take ? mem_rdata : best_val_q;

  // Read address follows the sequencer.
  always_comb begin
    case (state_q)
      ST_SCAN_CUR,
      ST_SCAN_QRY:  mem_raddr = {st_q, cnt_q[ACT_W-1:0]};
      ST_SCAN_NEXT: mem_raddr = {next_st, cnt_q[ACT_W-1:0]};
      default:      mem_raddr = {st_q, act_q};
    endcase
  end

  // Reward of the chosen action.
  always_comb begin
    case (act_q)
      2'd0:    reward = $signed(reward_fwd_q);
      2'd1:    reward = $signed(reward_bwd_q);
      2'd2:    reward = $signed(reward_stop_q);
      default: reward = $signed(reward_left_q);
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      ST_MUL_OLD: begin
        mul_a = TW'(old_q);
        mul_b = $signed(10'd256 - {2'b00, learn_rate_q});
      end
      ST_MUL_TGT: begin
        mul_a = target_q;
        mul_b = $signed({2'b00, learn_rate_q});
      end
      default: begin
        mul_a = TW'(best_val_q);
        mul_b = $signed({2'b00, discount_q});
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Floor divide by 256 and saturate to the table width.
  assign acc_sh  = acc_q >>> 8;
  assign nv_fits = (&acc_sh[AW-1:Q_WIDTH-1]) || ~(|acc_sh[AW-1:Q_WIDTH-1]);
  always_comb begin
    if (nv_fits) begin
      nv_sat = acc_sh[Q_WIDTH-1:0];
    end else if (acc_sh[AW-1]) begin
      nv_sat = {1'b1, {(Q_WIDTH-1){1'b0}}};
    end else begin
      nv_sat = {1'b0, {(Q_WIDTH-1){1'b1}}};
    end
  end

  // Epsilon decay and the explore test.
  assign eps_dec     = 8'(({8'd0, eps_q} * DECAY_NUM) >> 8);
  assign explore     = {cmd_i.draw, 8'h00} <= 15'({7'd0, eps_q} * EXPLORE_SCALE);
  assign qs_in_range = 32'(cmd_i.query_state) < 32'(NUM_STATES);

  // Table write port: clearing pass or the learn update.
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : {st_q, act_q};
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : nv_sat;

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    st_d        = st_q;
    cur_state_d = cur_state_q;
    eps_d       = eps_q;
    act_d       = act_q;
    expl_d      = expl_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    old_d       = old_q;
    target_d    = target_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    done_d      = 1'b0;
    result_d    = result_q;

    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          cnt_d = 3'd0;
          if (cmd_i.opcode == OP_QUERY) begin
            if (qs_in_range) begin
              st_d    = SW'(cmd_i.query_state);
              state_d = ST_SCAN_QRY;
            end else begin
              // A state beyond the table reads nothing and answers at once.
              done_d               = 1'b1;
              result_d.action      = '0;
              result_d.q_value     = '0;
              result_d.state_index = cmd_i.query_state;
              result_d.explored    = 1'b0;
            end
          end else begin
            st_d    = cur_state_q;
            expl_d  = explore;
            act_d   = cmd_i.random_action;
            state_d = explore ? ST_SCAN_NEXT : ST_SCAN_CUR;
          end
        end
      end

      ST_SCAN_CUR,
      ST_SCAN_NEXT,
      ST_SCAN_QRY: begin
        if (cnt_q != 3'd0) begin
          best_val_d = scan_val;
          best_idx_d = scan_idx;
        end
        if (cnt_q == 3'd4) begin
          cnt_d = 3'd0;
          case (state_q)
            ST_SCAN_CUR: begin
              act_d   = scan_idx;
              state_d = ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT: begin
              state_d = ST_READ_OLD;
            end
            default: begin
              done_d               = 1'b1;
              result_d.action      = scan_idx;
              result_d.q_value     = 16'(scan_val);
              result_d.state_index = 4'(st_q);
              result_d.explored    = 1'b0;
              state_d              = ST_IDLE;
            end
          endcase
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      // Old entry read is in flight; the row maximum is in best_val_q.
      ST_READ_OLD: begin
        state_d = ST_MUL_G;
      end

      // gamma * qmax
      ST_MUL_G: begin
        old_d   = mem_rdata;
        prod_d  = mul_p;
        state_d = ST_MUL_OLD;
      end

      // target = reward*256 + floor(gamma*qmax/256); (256-alpha) * old
      ST_MUL_OLD: begin
        target_d = (TW'(reward) <<< 8) + TW'(prod_q >>> 8);
        prod_d   = mul_p;
        state_d  = ST_MUL_TGT;
      end

      // alpha * target
      ST_MUL_TGT: begin
        acc_d   = AW'(prod_q);
        prod_d  = mul_p;
        state_d = ST_ACC;
      end

      ST_ACC: begin
        acc_d   = acc_q + AW'(prod_q);
        state_d = ST_WRITE;
      end

      // Store the update, advance the state and decay epsilon.
      ST_WRITE: begin
        done_d               = 1'b1;
        result_d.action      = act_q;
        result_d.q_value     = 16'(nv_sat);
        result_d.state_index = 4'(st_q);
        result_d.explored    = expl_q;
        cur_state_d          = next_st;
        eps_d                = (eps_dec < explore_floor_q) ? explore_start_q : eps_dec;
        state_d              = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      st_q        <= '0;
      cur_state_q <= '0;
      eps_q       <= EPSILON_RST;
      act_q       <= '0;
      expl_q      <= 1'b0;
      best_val_q  <= '0;
      best_idx_q  <= '0;
      old_q       <= '0;
      target_q    <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      done_q      <= 1'b0;
      result_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      st_q        <= st_d;
      cur_state_q <= cur_state_d;
      eps_q       <= eps_d;
      act_q       <= act_d;
      expl_q      <= expl_d;
      best_val_q  <= best_val_d;
      best_idx_q  <= best_idx_d;
      old_q       <= old_d;
      target_q    <= target_d;
      prod_q      <= prod_d;
      acc_q       <= acc_d;
      done_q      <= done_d;
      result_q    <= result_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // The update step always ends in a result transfer with the block free again.
  `TQLE_ASSERT_NEXT(a_write_ends_item, state_q == ST_WRITE, done_o && !busy,
                    "update step did not finish the item")
  // Only a learn item can report an explored action.
  `TQLE_ASSERT_NOW(a_explore_from_learn, done_o && result_o.explored,
                   $past(state_q == ST_WRITE), "explored flag on a query result")
  // An accepted learn item keeps the block busy for its work.
  `TQLE_ASSERT_NEXT(a_learn_goes_busy, start && !busy && (cmd_i.opcode == OP_LEARN),
                    busy, "learn item did not start")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the tabular Q-learning engine top level.
// Depends on tqle_pkg and tabular_q_learning_engine_top; it predicts each result itself
// and checks every result transfer against it, covering learn, query and configuration.
module tb_top;
  import tqle_pkg::*;

  localparam int unsigned NUM_STATES  = 10;
  localparam int unsigned Q_WIDTH     = 16;
  localparam longint      Q_MAX       = 32767;
  localparam longint      Q_MIN       = -32768;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned MAX_REPORTS = 40;

  // Clock, reset and block ports; the driven inputs are known from time zero.
  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  cmd_t                  cmd_i   = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  always #10 clk_i = ~clk_i;

  tabular_q_learning_engine_top #(
    .NUM_STATES(NUM_STATES),
    .Q_WIDTH   (Q_WIDTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the engine: registers, Q table, current state and exploration rate.
  logic [7:0]  reg_shadow [8];
  longint      q_shadow [NUM_STATES*NUM_ACTIONS];
  int unsigned state_shadow;
  int unsigned epsilon_shadow;

  result_t     expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  function automatic void reset_shadow();
    reg_shadow[REG_LEARN_RATE]      = LEARN_RATE_RST;
    reg_shadow[REG_DISCOUNT]        = DISCOUNT_RST;
    reg_shadow[REG_EXPLORE_START]   = EXPLORE_START_RST;
    reg_shadow[REG_EXPLORE_FLOOR]   = EXPLORE_FLOOR_RST;
    reg_shadow[REG_REWARD_FORWARD]  = REWARD_FORWARD_RST;
    reg_shadow[REG_REWARD_BACKWARD] = REWARD_BACKWARD_RST;
    reg_shadow[REG_REWARD_STOP]     = REWARD_STOP_RST;
    reg_shadow[REG_REWARD_LEFT]     = REWARD_LEFT_RST;
    foreach (q_shadow[i]) q_shadow[i] = 0;
    state_shadow   = 0;
    epsilon_shadow = EPSILON_RST;
  endfunction

  // Greedy action of a row: the true maximum, lowest action index on ties.
  function automatic int unsigned greedy_action(int unsigned s);
    int unsigned best;
    best = 0;
    for (int unsigned a = 1; a < NUM_ACTIONS; a++) begin
      if (q_shadow[s*NUM_ACTIONS + a] > q_shadow[s*NUM_ACTIONS + best]) best = a;
    end
    return best;
  endfunction

  // Works out the result of one accepted command and advances the shadow state.
  function automatic result_t apply_command(cmd_t c);
    result_t     r;
    int unsigned s;
    int unsigned nxt;
    int unsigned act;
    int          reward;
    longint      lr;
    longint      qmax;
    longint      target;
    longint      new_q;
    r = '0;
    if (c.opcode == OP_QUERY) begin
      if (c.query_state < NUM_STATES) begin
        act        = greedy_action(c.query_state);
        r.action   = act[1:0];
        r.q_value  = 16'(q_shadow[c.query_state*NUM_ACTIONS + act]);
      end
      r.state_index = c.query_state;
      return r;
    end

    s   = state_shadow;
    nxt = (s + 1 >= NUM_STATES) ? 0 : s + 1;
    if (int'(c.draw) * 256 <= int'(epsilon_shadow) * int'(EXPLORE_SCALE)) begin
      act        = c.random_action;
      r.explored = 1'b1;
    end else begin
      act = greedy_action(s);
    end
    reward = $signed(reg_shadow[int'(REG_REWARD_FORWARD) + act]);
    qmax   = q_shadow[nxt*NUM_ACTIONS + greedy_action(nxt)];
    target = longint'(reward) * 256 + ((longint'(reg_shadow[REG_DISCOUNT]) * qmax) >>> 8);
    lr     = longint'(reg_shadow[REG_LEARN_RATE]);
    new_q  = ((256 - lr) * q_shadow[s*NUM_ACTIONS + act] + lr * target) >>> 8;
    if (new_q > Q_MAX) new_q = Q_MAX;
    if (new_q < Q_MIN) new_q = Q_MIN;
    q_shadow[s*NUM_ACTIONS + act] = new_q;

    state_shadow   = nxt;
    epsilon_shadow = (epsilon_shadow * int'(DECAY_NUM)) >> 8;
    if (epsilon_shadow < reg_shadow[REG_EXPLORE_FLOOR]) begin
      epsilon_shadow = reg_shadow[REG_EXPLORE_START];
    end

    r.action      = act[1:0];
    r.q_value     = 16'(new_q);
    r.state_index = s[3:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(op_e op, int unsigned draw, int unsigned ra,
                                    int unsigned qs);
    cmd_t c;
    c.opcode        = op;
    c.draw          = 7'(draw);
    c.random_action = 2'(ra);
    c.query_state   = 4'(qs);
    return c;
  endfunction

  // Mostly learn events with in-range draws; some queries and out-of-range draws.
  function automatic cmd_t random_cmd();
    cmd_t c;
    c.opcode        = ($urandom_range(0, 9) < 7) ? OP_LEARN : OP_QUERY;
    c.draw          = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 99))
                                                   : 7'($urandom_range(100, 127));
    c.random_action = 2'($urandom_range(0, 3));
    c.query_state   = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Register values: often one of the extremes, otherwise anything.
  function automatic logic [7:0] pick_reg_value(reg_idx_e idx);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (idx >= REG_REWARD_FORWARD) ? 8'h80 : 8'h00;
    hi = (idx >= REG_REWARD_FORWARD) ? 8'h7F : 8'hFF;
    case ($urandom_range(0, 3))
      0: begin
        return lo;
      end
      1: begin
        return hi;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic flag_mismatch(string field, longint expv, longint gotv);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, gotv);
    end
  endtask

  // Hands one command to the block and records its expected result on acceptance.
  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(apply_command(c));
  endtask

  // Sender gap with start held low.
  task automatic pause_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Holds off new commands until every pending result has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  // One configuration transfer: setup phase, then access until pready.
  task automatic cfg_transfer(bit wr, reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_write(reg_idx_e idx, logic [7:0] value);
    cfg_transfer(1'b1, idx, {24'b0, value});
    reg_shadow[idx] = value;
  endtask

  task automatic reg_read_check(reg_idx_e idx);
    cfg_transfer(1'b0, idx, '0);
    if (prdata[7:0] !== reg_shadow[idx]) begin
      flag_mismatch($sformatf("register %s readback", idx.name()), reg_shadow[idx],
                    prdata[7:0]);
    end
  endtask

  // Compares each result transfer, field by field, with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result, q_value", 0, result_o.q_value);
      end else begin
        exp_r = expected_results.pop_front();
        if (result_o.action !== exp_r.action) begin
          flag_mismatch("action", exp_r.action, result_o.action);
        end
        if (result_o.q_value !== exp_r.q_value) begin
          flag_mismatch("q_value", exp_r.q_value, result_o.q_value);
        end
        if (result_o.state_index !== exp_r.state_index) begin
          flag_mismatch("state_index", exp_r.state_index, result_o.state_index);
        end
        if (result_o.explored !== exp_r.explored) begin
          flag_mismatch("explored", exp_r.explored, result_o.explored);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset values of every register, then queries of a cleared table, in and out of range.
  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) reg_read_check(reg_idx_e'(i));
    cfg_release();
    send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    send_cmd(make_cmd(OP_QUERY, 127, 3, NUM_STATES - 1));
    send_cmd(make_cmd(OP_QUERY, 0, 0, NUM_STATES));
    drain();
  endtask

  // Every register at both extremes with readback, then back to the reset values.
  task automatic test_register_access();
    logic [7:0] lo;
    logic [7:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo = (i >= int'(REG_REWARD_FORWARD)) ? 8'h80 : 8'h00;
      hi = (i >= int'(REG_REWARD_FORWARD)) ? 8'h7F : 8'hFF;
      reg_write(reg_idx_e'(i), hi);
      reg_read_check(reg_idx_e'(i));
      reg_write(reg_idx_e'(i), lo);
      reg_read_check(reg_idx_e'(i));
    end
    reg_write(REG_LEARN_RATE, LEARN_RATE_RST);
    reg_write(REG_DISCOUNT, DISCOUNT_RST);
    reg_write(REG_EXPLORE_START, EXPLORE_START_RST);
    reg_write(REG_EXPLORE_FLOOR, EXPLORE_FLOOR_RST);
    reg_write(REG_REWARD_FORWARD, REWARD_FORWARD_RST);
    reg_write(REG_REWARD_BACKWARD, REWARD_BACKWARD_RST);
    reg_write(REG_REWARD_STOP, REWARD_STOP_RST);
    reg_write(REG_REWARD_LEFT, REWARD_LEFT_RST);
    cfg_release();
  endtask

  // Exploring and greedy learn events at the draw extremes, ties in fresh rows,
  // draws past 99 and queries of learned and out-of-range states.
  task automatic test_learn_basics();
    send_cmd(make_cmd(OP_LEARN, 0, 3, 15));
    send_cmd(make_cmd(OP_LEARN, 127, 2, 0));
    send_cmd(make_cmd(OP_LEARN, 99, 1, 9));
    send_cmd(make_cmd(OP_LEARN, 100, 0, 3));
    send_cmd(make_cmd(OP_LEARN, 85, 1, 0));
    send_cmd(make_cmd(OP_LEARN, 1, 2, 0));
    send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    send_cmd(make_cmd(OP_QUERY, 127, 3, 1));
    send_cmd(make_cmd(OP_QUERY, 50, 2, 15));
    drain();
  endtask

  // Largest rate, discount and reward: a full lap of the states drives Q to its ceiling.
  task automatic test_saturation();
    reg_write(REG_LEARN_RATE, 8'hFF);
    reg_write(REG_DISCOUNT, 8'hFF);
    reg_write(REG_EXPLORE_START, 8'hFF);
    reg_write(REG_EXPLORE_FLOOR, 8'h00);
    reg_write(REG_REWARD_FORWARD, 8'h7F);
    reg_write(REG_REWARD_BACKWARD, 8'h7F);
    reg_write(REG_REWARD_STOP, 8'h7F);
    reg_write(REG_REWARD_LEFT, 8'h7F);
    cfg_release();
    for (int n = 0; n < NUM_STATES + 1; n++) begin
      send_cmd(make_cmd(OP_LEARN, 0, $urandom_range(0, 3), $urandom_range(0, 15)));
    end
    send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
    drain();
  endtask

  // Random traffic over several register settings and sender gap rates.
  task automatic test_random_traffic();
    cmd_t        c;
    int unsigned idle_pct;
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = (p < 2) ? 9 : (p < 4) ? 45 : 0;
      for (int i = 0; i < 8; i++) begin
        // One setting pushes toward the negative ceiling.
        if (p == 3 && (i == int'(REG_LEARN_RATE) || i == int'(REG_DISCOUNT))) begin
          reg_write(reg_idx_e'(i), 8'hFF);
        end else if (p == 3 && i >= int'(REG_REWARD_FORWARD)) begin
          reg_write(reg_idx_e'(i), 8'h80);
        end else begin
          reg_write(reg_idx_e'(i), pick_reg_value(reg_idx_e'(i)));
        end
      end
      cfg_release();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c = random_cmd();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          pause_cycles($urandom_range(1, 6));
        end
        send_cmd(c);
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_register_access();
    test_learn_basics();
    test_saturation();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      flag_mismatch("pending result count", 0, expected_results.size());
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
